// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BFID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BFID_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/bfid_pkg.sv =====
package bfid_pkg;

  localparam int unsigned MAX_SRC_EDGE_DEF   = 4096;
  localparam int unsigned MAX_THUMB_EDGE_DEF = 128;
  localparam int unsigned SUM_WIDTH_DEF      = 32;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MAX_EDGE_W = 8;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned NUM_LANES  = 4;

  localparam logic [CFG_DATA_W-1:0] SRC_DIM_RST  = 13'd1;
  localparam logic [MAX_EDGE_W-1:0] MAX_EDGE_RST = 8'd110;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_MAX_EDGE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSTART,
    ST_GWAIT,
    ST_COL,
    ST_AVG
  } state_e;

  typedef enum logic [1:0] {
    GEO_THUMB_W = 2'd0,
    GEO_THUMB_H = 2'd1,
    GEO_STEP_W  = 2'd2,
    GEO_STEP_H  = 2'd3
  } geo_step_e;

  typedef struct packed {
    logic acc;
    logic colhit;
    logic wr;
    logic first;
    logic avg;
  } lane_ctl_t;

endpackage

// ===== sv/bfid_if.sv =====
interface bfid_pix_if;
  logic                         valid;
  logic                         ready;
  logic [bfid_pkg::PIX_W-1:0]   pix_red;
  logic [bfid_pkg::PIX_W-1:0]   pix_green;
  logic [bfid_pkg::PIX_W-1:0]   pix_blue;
  logic [bfid_pkg::PIX_W-1:0]   pix_alpha;

  modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, pix_alpha, output ready);
endinterface

interface bfid_avg_if;
  logic                         valid;
  logic                         ready;
  logic [bfid_pkg::PIX_W-1:0]   avg_red;
  logic [bfid_pkg::PIX_W-1:0]   avg_green;
  logic [bfid_pkg::PIX_W-1:0]   avg_blue;
  logic [bfid_pkg::PIX_W-1:0]   avg_alpha;
  logic [bfid_pkg::POS_W-1:0]   thumb_x;
  logic [bfid_pkg::POS_W-1:0]   thumb_y;
  logic [bfid_pkg::DIM_W-1:0]   thumb_w;
  logic [bfid_pkg::DIM_W-1:0]   thumb_h;
  logic                         frame_last;

  modport source (output valid, avg_red, avg_green, avg_blue, avg_alpha, thumb_x, thumb_y,
                  thumb_w, thumb_h, frame_last, input ready);
  modport sink   (input valid, avg_red, avg_green, avg_blue, avg_alpha, thumb_x, thumb_y,
                  thumb_w, thumb_h, frame_last, output ready);
endinterface

// ===== sv/bfid_div.sv =====
module bfid_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          vld_q, vld_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    diff   = trial - {1'b0, den_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    vld_d  = vld_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      vld_d  = 1'b0;
      cnt_d  = CW'(NW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        vld_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = vld_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/bfid_lane.sv =====
module bfid_lane #(
  parameter int unsigned MAX_THUMB_EDGE = bfid_pkg::MAX_THUMB_EDGE_DEF,
  parameter int unsigned SUM_WIDTH      = bfid_pkg::SUM_WIDTH_DEF,
  parameter int unsigned AW             = 7,
  parameter int unsigned NDW            = 26
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfid_pkg::lane_ctl_t        ctl_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [bfid_pkg::PIX_W-1:0] pix_i,
  input  logic [NDW-1:0]             den_i,
  output logic                       done_o,
  output logic [bfid_pkg::PIX_W-1:0] avg_o
);

  logic [SUM_WIDTH-1:0] mem [MAX_THUMB_EDGE];
  logic [SUM_WIDTH-1:0] partial_q, partial_d;
  logic [SUM_WIDTH-1:0] tot_q;
  logic [SUM_WIDTH-1:0] rd_q;
  logic [AW-1:0]        addr_q;
  logic [SUM_WIDTH-1:0] sum_pix;
  logic [SUM_WIDTH-1:0] new_sum;
  logic [SUM_WIDTH-1:0] quo;

  function automatic logic [SUM_WIDTH-1:0] sat_add(logic [SUM_WIDTH-1:0] a,
                                                   logic [SUM_WIDTH-1:0] b);
    logic [SUM_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
  endfunction

  always_comb begin
    sum_pix   = sat_add(partial_q, SUM_WIDTH'(pix_i));
    new_sum   = ctl_i.first ? tot_q : sat_add(rd_q, tot_q);
    partial_d = partial_q;
    if (ctl_i.acc) begin
      partial_d = ctl_i.colhit ? '0 : sum_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
    end else begin
      partial_q <= partial_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc && ctl_i.colhit) begin
      rd_q   <= mem[addr_i];
      addr_q <= addr_i;
      tot_q  <= sum_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[addr_q] <= new_sum;
    end
  end

  bfid_div #(
    .NW (SUM_WIDTH),
    .DW (NDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.avg),
    .num_i   (new_sum),
    .den_i   (den_i),
    .done_o  (done_o),
    .quo_o   (quo),
    .rem_o   ()
  );

  assign avg_o = (|quo[SUM_WIDTH-1:bfid_pkg::PIX_W]) ? {bfid_pkg::PIX_W{1'b1}}
                                                     : quo[bfid_pkg::PIX_W-1:0];

endmodule

// ===== sv/box_filter_image_downscaler.sv =====
// Area-average image downscaler.
// pix_i takes RGBA source pixels in raster order, one request per pixel.
// avg_o gives one request per thumbnail pixel: the truncated channel means over
// its source rectangle, its position, the frame's thumbnail size and a
// last-of-frame flag. cfg_we_i/cfg_idx_i/cfg_wdata_i write source width,
// source height and max edge; they apply from the next frame start.
// Frame start: before the first pixel, four serial divides on one shared
// divider derive the thumbnail size and band steps.
// Per pixel: a pixel that closes a column band also passes through a column
// state (column-sum memory read, then write). Closing a rectangle adds
// the four lane divides, run in parallel, before the output register loads.
// The output register lets pixels flow while a result waits; a stalled
// receiver holds the block only when the next result is ready to load.
// Reset: registers back to 1x1 source and max edge 110; column sums are not
// cleared, each band's first row overwrites them.
`include "assert_macros.svh"

module box_filter_image_downscaler #(
  parameter int unsigned MAX_SRC_EDGE   = bfid_pkg::MAX_SRC_EDGE_DEF,
  parameter int unsigned MAX_THUMB_EDGE = bfid_pkg::MAX_THUMB_EDGE_DEF,
  parameter int unsigned SUM_WIDTH      = bfid_pkg::SUM_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfid_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bfid_pix_if.sink                        pix_i,
  bfid_avg_if.source                      avg_o
);

  localparam int unsigned SW  = $clog2(MAX_SRC_EDGE + 1);
  localparam int unsigned TBW = $clog2(MAX_THUMB_EDGE + 1);
  localparam int unsigned AW  = (MAX_THUMB_EDGE > 1) ? $clog2(MAX_THUMB_EDGE) : 1;
  localparam int unsigned GNW = SW + TBW + 2;
  localparam int unsigned GDW = SW + 1;
  localparam int unsigned NDW = 2 * SW;
  localparam int unsigned PW  = bfid_pkg::PIX_W;

  bfid_pkg::state_e    state_q, state_d;
  bfid_pkg::geo_step_e step_q, step_d;
  bfid_pkg::lane_ctl_t lane_ctl;

  logic [bfid_pkg::CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;
  logic [bfid_pkg::MAX_EDGE_W-1:0] cfg_m_q;

  logic          geo_ok_q, geo_ok_d;
  logic          dirty_q, dirty_d;
  logic [SW-1:0]  lat_w_q, lat_h_q, long_q;
  logic [TBW-1:0] m_q;
  logic [TBW-1:0] dw_q, dh_q;
  logic [SW-1:0]  cq_w_q, cq_h_q;
  logic [TBW-1:0] cr_w_q, cr_h_q;

  logic [SW-1:0]  src_col_q, src_col_d, src_row_q, src_row_d;
  logic [TBW-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [SW-1:0]  col_end_q, col_end_d, col_start_q, col_start_d;
  logic [TBW-1:0] col_rem_q, col_rem_d;
  logic [SW-1:0]  row_end_q, row_end_d, band_start_q, band_start_d;
  logic [TBW-1:0] row_rem_q, row_rem_d;

  logic           first_q, rowhit_q;
  logic [NDW-1:0] n_q;
  logic [bfid_pkg::POS_W-1:0] pend_x_q, pend_y_q;
  logic           pend_last_q;

  logic           out_vld_q, out_vld_d;
  logic [PW-1:0]  out_avg_q [bfid_pkg::NUM_LANES];
  logic [bfid_pkg::POS_W-1:0] out_x_q, out_y_q;
  logic [bfid_pkg::DIM_W-1:0] out_w_q, out_h_q;
  logic           out_last_q;

  logic           fire, sof, colhit, rowhit, col_wrap, row_wrap, out_load, chain_go;
  logic [SW:0]    src_col_inc, src_row_inc;
  logic [TBW:0]   col_rem_sum, row_rem_sum;
  logic [SW-1:0]  col_end_adv, row_end_adv;
  logic [TBW-1:0] col_rem_adv, row_rem_adv;

  logic           div_start, div_done;
  logic [GNW-1:0] div_num, div_quo;
  logic [GDW-1:0] div_den, div_rem;
  logic [TBW-1:0] thumb_edge;

  logic [bfid_pkg::NUM_LANES-1:0] lane_done;
  logic [PW-1:0]  lane_avg [bfid_pkg::NUM_LANES];
  logic [PW-1:0]  lane_pix [bfid_pkg::NUM_LANES];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= bfid_pkg::SRC_DIM_RST;
      cfg_h_q <= bfid_pkg::SRC_DIM_RST;
      cfg_m_q <= bfid_pkg::MAX_EDGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfid_pkg::CFG_SRC_WIDTH:  cfg_w_q <= cfg_wdata_i;
        bfid_pkg::CFG_SRC_HEIGHT: cfg_h_q <= cfg_wdata_i;
        bfid_pkg::CFG_MAX_EDGE:   cfg_m_q <= cfg_wdata_i[bfid_pkg::MAX_EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] clamp_src(logic [bfid_pkg::CFG_DATA_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) begin
      r = SW'(1);
    end else if (32'(v) > MAX_SRC_EDGE) begin
      r = SW'(MAX_SRC_EDGE);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  assign fire   = pix_i.valid && pix_i.ready;
  assign sof    = (src_col_q == '0) && (src_row_q == '0);
  assign src_col_inc = {1'b0, src_col_q} + 1'b1;
  assign src_row_inc = {1'b0, src_row_q} + 1'b1;
  assign colhit = src_col_inc >= {1'b0, col_end_q};
  assign rowhit = src_row_inc >= {1'b0, row_end_q};
  assign col_wrap = src_col_inc >= {1'b0, lat_w_q};
  assign row_wrap = src_row_inc >= {1'b0, lat_h_q};
  assign chain_go = (state_q == bfid_pkg::ST_IDLE) && !geo_ok_q;
  assign out_load = (state_q == bfid_pkg::ST_AVG) && (&lane_done)
                    && (!out_vld_q || avg_o.ready);

  assign col_rem_sum = {1'b0, col_rem_q} + {1'b0, cr_w_q};
  assign row_rem_sum = {1'b0, row_rem_q} + {1'b0, cr_h_q};
  always_comb begin
    col_end_adv = col_end_q + cq_w_q;
    col_rem_adv = col_rem_sum[TBW-1:0];
    if (col_rem_sum >= {1'b0, dw_q}) begin
      col_end_adv = col_end_q + cq_w_q + 1'b1;
      col_rem_adv = TBW'(col_rem_sum - {1'b0, dw_q});
    end
    row_end_adv = row_end_q + cq_h_q;
    row_rem_adv = row_rem_sum[TBW-1:0];
    if (row_rem_sum >= {1'b0, dh_q}) begin
      row_end_adv = row_end_q + cq_h_q + 1'b1;
      row_rem_adv = TBW'(row_rem_sum - {1'b0, dh_q});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfid_pkg::ST_IDLE: begin
        if (!geo_ok_q) begin
          state_d = bfid_pkg::ST_GSTART;
        end else if (fire && colhit) begin
          state_d = bfid_pkg::ST_COL;
        end
      end
      bfid_pkg::ST_GSTART: state_d = bfid_pkg::ST_GWAIT;
      bfid_pkg::ST_GWAIT: begin
        if (div_done) begin
          state_d = (step_q == bfid_pkg::GEO_STEP_H) ? bfid_pkg::ST_IDLE
                                                      : bfid_pkg::ST_GSTART;
        end
      end
      bfid_pkg::ST_COL: state_d = rowhit_q ? bfid_pkg::ST_AVG : bfid_pkg::ST_IDLE;
      bfid_pkg::ST_AVG: begin
        if (out_load) begin
          state_d = bfid_pkg::ST_IDLE;
        end
      end
      default: state_d = bfid_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pix_i.ready     = (state_q == bfid_pkg::ST_IDLE) && geo_ok_q;
    div_start       = (state_q == bfid_pkg::ST_GSTART);
    lane_ctl.acc    = fire;
    lane_ctl.colhit = colhit;
    lane_ctl.wr     = (state_q == bfid_pkg::ST_COL);
    lane_ctl.first  = first_q;
    lane_ctl.avg    = (state_q == bfid_pkg::ST_COL) && rowhit_q;
  end

  // geometry divider operands
  always_comb begin
    case (step_q)
      bfid_pkg::GEO_THUMB_W: begin
        div_num = ((GNW'(lat_w_q) * GNW'(m_q)) << 1) + GNW'(long_q);
        div_den = {long_q, 1'b0};
      end
      bfid_pkg::GEO_THUMB_H: begin
        div_num = ((GNW'(lat_h_q) * GNW'(m_q)) << 1) + GNW'(long_q);
        div_den = {long_q, 1'b0};
      end
      bfid_pkg::GEO_STEP_W: begin
        div_num = GNW'(lat_w_q);
        div_den = GDW'(dw_q);
      end
      default: begin
        div_num = GNW'(lat_h_q);
        div_den = GDW'(dh_q);
      end
    endcase
  end

  bfid_div #(
    .NW (GNW),
    .DW (GDW)
  ) u_geo_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign thumb_edge = (div_quo == '0) ? TBW'(1) : TBW'(div_quo);

  always_comb begin
    geo_ok_d = geo_ok_q;
    dirty_d  = dirty_q;
    if (chain_go) begin
      dirty_d = 1'b0;
    end
    if (cfg_we_i) begin
      dirty_d = 1'b1;
      if (sof) begin
        geo_ok_d = 1'b0;
      end
    end
    if ((state_q == bfid_pkg::ST_GWAIT) && div_done && (step_q == bfid_pkg::GEO_STEP_H)
        && !dirty_q && !cfg_we_i) begin
      geo_ok_d = 1'b1;
    end
    if (fire && col_wrap && row_wrap) begin
      geo_ok_d = 1'b0;
    end
  end

  // raster walk
  always_comb begin
    step_d       = step_q;
    src_col_d    = src_col_q;
    src_row_d    = src_row_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    col_end_d    = col_end_q;
    col_rem_d    = col_rem_q;
    col_start_d  = col_start_q;
    row_end_d    = row_end_q;
    row_rem_d    = row_rem_q;
    band_start_d = band_start_q;
    if (chain_go) begin
      step_d = bfid_pkg::GEO_THUMB_W;
    end
    if ((state_q == bfid_pkg::ST_GWAIT) && div_done) begin
      step_d = bfid_pkg::geo_step_e'(step_q + 2'd1);
      if (step_q == bfid_pkg::GEO_STEP_H) begin
        src_col_d    = '0;
        src_row_d    = '0;
        cur_col_d    = '0;
        cur_row_d    = '0;
        col_start_d  = '0;
        band_start_d = '0;
        col_end_d    = cq_w_q;
        col_rem_d    = cr_w_q;
        row_end_d    = SW'(div_quo);
        row_rem_d    = TBW'(div_rem);
      end
    end
    if (fire) begin
      if (colhit) begin
        col_start_d = col_end_q;
        cur_col_d   = cur_col_q + 1'b1;
        col_end_d   = col_end_adv;
        col_rem_d   = col_rem_adv;
      end
      src_col_d = src_col_inc[SW-1:0];
      if (col_wrap) begin
        src_col_d   = '0;
        cur_col_d   = '0;
        col_start_d = '0;
        col_end_d   = cq_w_q;
        col_rem_d   = cr_w_q;
        if (rowhit) begin
          band_start_d = row_end_q;
          cur_row_d    = cur_row_q + 1'b1;
          row_end_d    = row_end_adv;
          row_rem_d    = row_rem_adv;
        end
        src_row_d = src_row_inc[SW-1:0];
        if (row_wrap) begin
          src_row_d    = '0;
          cur_row_d    = '0;
          band_start_d = '0;
        end
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (avg_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfid_pkg::ST_IDLE;
      step_q       <= bfid_pkg::GEO_THUMB_W;
      geo_ok_q     <= 1'b0;
      dirty_q      <= 1'b0;
      src_col_q    <= '0;
      src_row_q    <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      col_end_q    <= '0;
      col_rem_q    <= '0;
      col_start_q  <= '0;
      row_end_q    <= '0;
      row_rem_q    <= '0;
      band_start_q <= '0;
      dw_q         <= TBW'(1);
      dh_q         <= TBW'(1);
      rowhit_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      geo_ok_q     <= geo_ok_d;
      dirty_q      <= dirty_d;
      src_col_q    <= src_col_d;
      src_row_q    <= src_row_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      col_end_q    <= col_end_d;
      col_rem_q    <= col_rem_d;
      col_start_q  <= col_start_d;
      row_end_q    <= row_end_d;
      row_rem_q    <= row_rem_d;
      band_start_q <= band_start_d;
      out_vld_q    <= out_vld_d;
      if ((state_q == bfid_pkg::ST_GWAIT) && div_done) begin
        if (step_q == bfid_pkg::GEO_THUMB_W) begin
          dw_q <= (long_q <= SW'(m_q)) ? TBW'(lat_w_q) : thumb_edge;
        end
        if (step_q == bfid_pkg::GEO_THUMB_H) begin
          dh_q <= (long_q <= SW'(m_q)) ? TBW'(lat_h_q) : thumb_edge;
        end
      end
      if (fire) begin
        rowhit_q <= rowhit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_go) begin
      lat_w_q <= clamp_src(cfg_w_q);
      lat_h_q <= clamp_src(cfg_h_q);
      long_q  <= (clamp_src(cfg_w_q) > clamp_src(cfg_h_q)) ? clamp_src(cfg_w_q)
                                                           : clamp_src(cfg_h_q);
      m_q     <= (32'(cfg_m_q) > MAX_THUMB_EDGE) ? TBW'(MAX_THUMB_EDGE) : TBW'(cfg_m_q);
    end
    if ((state_q == bfid_pkg::ST_GWAIT) && div_done) begin
      if (step_q == bfid_pkg::GEO_STEP_W) begin
        cq_w_q <= SW'(div_quo);
        cr_w_q <= TBW'(div_rem);
      end
      if (step_q == bfid_pkg::GEO_STEP_H) begin
        cq_h_q <= SW'(div_quo);
        cr_h_q <= TBW'(div_rem);
      end
    end
    if (fire) begin
      first_q     <= (src_row_q == band_start_q);
      n_q         <= NDW'(col_end_q - col_start_q) * NDW'(row_end_q - band_start_q);
      pend_x_q    <= bfid_pkg::POS_W'(cur_col_q);
      pend_y_q    <= bfid_pkg::POS_W'(cur_row_q);
      pend_last_q <= col_wrap && row_wrap;
    end
    if (out_load) begin
      for (int i = 0; i < bfid_pkg::NUM_LANES; i++) begin
        out_avg_q[i] <= lane_avg[i];
      end
      out_x_q    <= pend_x_q;
      out_y_q    <= pend_y_q;
      out_w_q    <= bfid_pkg::DIM_W'(dw_q);
      out_h_q    <= bfid_pkg::DIM_W'(dh_q);
      out_last_q <= pend_last_q;
    end
  end

  // channel lanes
  assign lane_pix[0] = pix_i.pix_red;
  assign lane_pix[1] = pix_i.pix_green;
  assign lane_pix[2] = pix_i.pix_blue;
  assign lane_pix[3] = pix_i.pix_alpha;

  for (genvar g = 0; g < bfid_pkg::NUM_LANES; g++) begin : g_lane
    bfid_lane #(
      .MAX_THUMB_EDGE (MAX_THUMB_EDGE),
      .SUM_WIDTH      (SUM_WIDTH),
      .AW             (AW),
      .NDW            (NDW)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .addr_i (AW'(cur_col_q)),
      .pix_i  (lane_pix[g]),
      .den_i  ((n_q == '0) ? NDW'(1) : n_q),
      .done_o (lane_done[g]),
      .avg_o  (lane_avg[g])
    );
  end

  assign avg_o.valid      = out_vld_q;
  assign avg_o.avg_red    = out_avg_q[0];
  assign avg_o.avg_green  = out_avg_q[1];
  assign avg_o.avg_blue   = out_avg_q[2];
  assign avg_o.avg_alpha  = out_avg_q[3];
  assign avg_o.thumb_x    = out_x_q;
  assign avg_o.thumb_y    = out_y_q;
  assign avg_o.thumb_w    = out_w_q;
  assign avg_o.thumb_h    = out_h_q;
  assign avg_o.frame_last = out_last_q;

  `BFID_ASSERT(a_rem_below_width,
    geo_ok_q |-> (col_rem_q < dw_q && row_rem_q < dh_q), "band remainder out of range")
  `BFID_ASSERT(a_col_in_frame,
    geo_ok_q |-> (src_col_q < lat_w_q && src_row_q < lat_h_q), "source position outside frame")
  `BFID_NEVER(a_out_overwrite, out_load && out_vld_q && !avg_o.ready, "pending result overwritten")
  `BFID_ASSERT(a_lanes_in_step,
    (state_q == bfid_pkg::ST_AVG) |-> ($countones(lane_done) == 0 || &lane_done),
    "lane dividers out of step")

endmodule
